/* rtl/lca_pkg.sv */
// Package for the life-like automaton block: sizes, codes and shared types.
// Used by lca_row_unit and the top level in rtl; depends on nothing.
package lca_pkg;

	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;
	localparam int COL_AW   = $clog2(MAX_COLS);
	localparam int ROW_AW   = $clog2(MAX_ROWS);
	localparam int SIZE_W   = 7;
	localparam int MASK_W   = 9;
	localparam int NB_W     = 4;

	typedef logic [COL_AW-1:0]   col_t;
	typedef logic [ROW_AW-1:0]   row_t;
	typedef logic [SIZE_W-1:0]   size_t;
	typedef logic [MASK_W-1:0]   mask_t;
	typedef logic [NB_W-1:0]     nbcnt_t;
	typedef logic [MAX_COLS-1:0] word_t;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_READ    = 2'd1,
		CMD_ADVANCE = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		CFG_BIRTH    = 2'd0,
		CFG_SURVIVAL = 2'd1,
		CFG_COLS     = 2'd2,
		CFG_ROWS     = 2'd3
	} cfg_idx_e;

	typedef struct packed {
		mask_t birth;
		mask_t survival;
		col_t  col_last;
	} rule_t;

endpackage

/* rtl/lca_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
module lca_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/lca_row_unit.sv */
// Row update unit: neighbour counts and birth/survival rule for one grid row.
// Depends on lca_pkg.
module lca_row_unit (
	input  lca_pkg::rule_t rule,
	input  lca_pkg::word_t up,
	input  lca_pkg::word_t mid,
	input  lca_pkg::word_t dn,
	input  lca_pkg::size_t cols_use,
	output lca_pkg::word_t nxt,
	output logic           changed
);

	lca_pkg::word_t up_lf, mid_lf, dn_lf;
	lca_pkg::word_t up_rt, mid_rt, dn_rt;

	assign up_lf  = {up[lca_pkg::MAX_COLS-2:0], up[rule.col_last]};
	assign mid_lf = {mid[lca_pkg::MAX_COLS-2:0], mid[rule.col_last]};
	assign dn_lf  = {dn[lca_pkg::MAX_COLS-2:0], dn[rule.col_last]};
	assign up_rt  = {up[0], up[lca_pkg::MAX_COLS-1:1]};
	assign mid_rt = {mid[0], mid[lca_pkg::MAX_COLS-1:1]};
	assign dn_rt  = {dn[0], dn[lca_pkg::MAX_COLS-1:1]};

	always_comb begin
		lca_pkg::nbcnt_t cnt;
		logic            u_r, m_r, d_r, nv;
		nxt     = mid;
		changed = 1'b0;
		for (int c = 0; c < lca_pkg::MAX_COLS; c++) begin
			if (lca_pkg::col_t'(c) == rule.col_last) begin
				u_r = up[0];
				m_r = mid[0];
				d_r = dn[0];
			end else begin
				u_r = up_rt[c];
				m_r = mid_rt[c];
				d_r = dn_rt[c];
			end
			cnt = lca_pkg::nbcnt_t'(up_lf[c]) + lca_pkg::nbcnt_t'(up[c])
				+ lca_pkg::nbcnt_t'(u_r) + lca_pkg::nbcnt_t'(mid_lf[c])
				+ lca_pkg::nbcnt_t'(m_r) + lca_pkg::nbcnt_t'(dn_lf[c])
				+ lca_pkg::nbcnt_t'(dn[c]) + lca_pkg::nbcnt_t'(d_r);
			nv = mid[c] ? rule.survival[cnt] : rule.birth[cnt];
			if (lca_pkg::size_t'(c) < cols_use) begin
				nxt[c] = nv;
				if (nv != mid[c]) begin
					changed = 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/lifelike_automaton_generation_step.sv */
// Top level of the life-like automaton block: configuration registers,
// command sequencer and grid storage. Depends on lca_pkg, lca_ram, lca_row_unit.
//
// Usage:
//  s_tvalid/s_tready/s_tdata carry one command item; m_tvalid/m_tready/m_tdata
//  return exactly one result item per command. cfg_we/cfg_index/cfg_data write
//  the rule masks and the grid size; the user must do so only while no command
//  is in flight; the block does not enforce it. The grid is held one row per
//  RAM word; a single row update unit is reused for every row of a generation.
//  A clear goes straight to its result; write and read fetch the row, and a
//  write stores it back with the new cell; advance reads the last row, row 0
//  and row 1, then updates rows_in_use rows, the row count clamped to 1 to 64.
//  The advance sweep is set by the single RAM read port: one row per cycle.
//  s_tready is high only while the sequencer is idle; one item is in work at a
//  time. A result waits in the output register while m_tready is low; the
//  next item is still taken, and its result is held back until the register
//  empties.
//  Reset clears the grid to dead cells at once (per-row valid flags, no
//  clearing pass) and loads birth mask 8, survival mask 12, size 64 x 64.
module lifelike_automaton_generation_step (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [15:0] s_tdata,   // command[1:0], col[7:2], row[13:8], cell_value[14]
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // read_value[0], any_changed[1]
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MODIFY,
		ST_ADV_UP,
		ST_ADV_MID,
		ST_ADV_DN0,
		ST_ADV_ROW,
		ST_DONE
	} state_t;

	state_t state_q;

	lca_pkg::mask_t birth_q, survival_q;
	lca_pkg::size_t cols_q, rows_q;
	lca_pkg::size_t cols_use, rows_use;
	lca_pkg::row_t  row_last;
	lca_pkg::rule_t rule;

	lca_pkg::cmd_e  cmd_q;
	lca_pkg::col_t  col_q;
	lca_pkg::row_t  row_q;
	logic           val_q;
	lca_pkg::row_t  cur_q;
	logic           rd_bit_q;
	logic           changed_q;
	logic           m_tvalid_q;
	logic           read_value_q;
	logic           any_changed_q;
	logic           fill_q;
	logic [lca_pkg::MAX_ROWS-1:0] valid_q;
	logic           rd_valid_s1;
	lca_pkg::word_t up_q, mid_q, row0_q;

	lca_pkg::cmd_e  in_cmd;
	lca_pkg::col_t  in_col, in_col_cl;
	lca_pkg::row_t  in_row, in_row_cl;
	logic           accept, out_load, last_row;
	lca_pkg::size_t nxt2;

	logic           ram_we, ram_re;
	lca_pkg::row_t  ram_waddr, ram_raddr;
	lca_pkg::word_t ram_wdata, ram_rdata;
	lca_pkg::word_t rd_word, mod_word, dn_word, row_nxt;
	logic           row_chg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q    <= lca_pkg::mask_t'(8);
			survival_q <= lca_pkg::mask_t'(12);
			cols_q     <= lca_pkg::size_t'(64);
			rows_q     <= lca_pkg::size_t'(64);
		end else if (cfg_we) begin
			unique case (lca_pkg::cfg_idx_e'(cfg_index))
				lca_pkg::CFG_BIRTH:    birth_q    <= cfg_data;
				lca_pkg::CFG_SURVIVAL: survival_q <= cfg_data;
				lca_pkg::CFG_COLS:     cols_q     <= cfg_data[lca_pkg::SIZE_W-1:0];
				lca_pkg::CFG_ROWS:     rows_q     <= cfg_data[lca_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cols_q == '0) begin
			cols_use = lca_pkg::size_t'(1);
		end else if (cols_q > lca_pkg::size_t'(lca_pkg::MAX_COLS)) begin
			cols_use = lca_pkg::size_t'(lca_pkg::MAX_COLS);
		end else begin
			cols_use = cols_q;
		end
		if (rows_q == '0) begin
			rows_use = lca_pkg::size_t'(1);
		end else if (rows_q > lca_pkg::size_t'(lca_pkg::MAX_ROWS)) begin
			rows_use = lca_pkg::size_t'(lca_pkg::MAX_ROWS);
		end else begin
			rows_use = rows_q;
		end
	end

	assign row_last      = lca_pkg::row_t'(rows_use - lca_pkg::size_t'(1));
	assign rule.birth    = birth_q;
	assign rule.survival = survival_q;
	assign rule.col_last = lca_pkg::col_t'(cols_use - lca_pkg::size_t'(1));

	assign in_cmd    = lca_pkg::cmd_e'(s_tdata[1:0]);
	assign in_col    = s_tdata[7:2];
	assign in_row    = s_tdata[13:8];
	assign in_col_cl = (lca_pkg::size_t'(in_col) >= cols_use) ? rule.col_last : in_col;
	assign in_row_cl = (lca_pkg::size_t'(in_row) >= rows_use) ? row_last : in_row;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign last_row = (lca_pkg::size_t'(cur_q) + lca_pkg::size_t'(1)) == rows_use;
	assign nxt2     = lca_pkg::size_t'(cur_q) + lca_pkg::size_t'(2);

	assign rd_word = rd_valid_s1 ? ram_rdata : {lca_pkg::MAX_COLS{fill_q}};
	assign dn_word = last_row ? row0_q : rd_word;

	always_comb begin
		mod_word        = rd_word;
		mod_word[col_q] = val_q;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = cur_q;
		ram_raddr = row_q;
		ram_wdata = row_nxt;
		unique case (state_q)
			ST_FETCH: begin
				ram_re = 1'b1;
			end
			ST_MODIFY: begin
				ram_we    = (cmd_q == lca_pkg::CMD_WRITE);
				ram_waddr = row_q;
				ram_wdata = mod_word;
			end
			ST_ADV_UP: begin
				ram_re    = 1'b1;
				ram_raddr = row_last;
			end
			ST_ADV_MID: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			ST_ADV_DN0: begin
				ram_re    = 1'b1;
				ram_raddr = lca_pkg::row_t'(1);
			end
			ST_ADV_ROW: begin
				ram_we    = 1'b1;
				ram_re    = (nxt2 < rows_use);
				ram_raddr = lca_pkg::row_t'(nxt2);
			end
			default: ;
		endcase
	end

	lca_ram #(
		.WIDTH(lca_pkg::MAX_COLS),
		.DEPTH(lca_pkg::MAX_ROWS)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lca_row_unit u_row (
		.rule    (rule),
		.up      (up_q),
		.mid     (mid_q),
		.dn      (dn_word),
		.cols_use(cols_use),
		.nxt     (row_nxt),
		.changed (row_chg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmd_q         <= lca_pkg::CMD_WRITE;
			col_q         <= '0;
			row_q         <= '0;
			val_q         <= 1'b0;
			cur_q         <= '0;
			rd_bit_q      <= 1'b0;
			changed_q     <= 1'b0;
			m_tvalid_q    <= 1'b0;
			read_value_q  <= 1'b0;
			any_changed_q <= 1'b0;
			fill_q        <= 1'b0;
			valid_q       <= '0;
			rd_valid_s1   <= 1'b0;
			up_q          <= '0;
			mid_q         <= '0;
			row0_q        <= '0;
		end else begin
			if (ram_re) begin
				rd_valid_s1 <= valid_q[ram_raddr];
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q    <= 1'b1;
				read_value_q  <= (cmd_q == lca_pkg::CMD_READ) && rd_bit_q;
				any_changed_q <= (cmd_q == lca_pkg::CMD_ADVANCE) && changed_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q     <= in_cmd;
						col_q     <= in_col_cl;
						row_q     <= in_row_cl;
						val_q     <= s_tdata[14];
						changed_q <= 1'b0;
						unique case (in_cmd)
							lca_pkg::CMD_WRITE,
							lca_pkg::CMD_READ:    state_q <= ST_FETCH;
							lca_pkg::CMD_ADVANCE: state_q <= ST_ADV_UP;
							lca_pkg::CMD_CLEAR: begin
								valid_q <= '0;
								fill_q  <= s_tdata[14];
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_MODIFY;
				end
				ST_MODIFY: begin
					rd_bit_q <= rd_word[col_q];
					state_q  <= ST_DONE;
				end
				ST_ADV_UP: begin
					state_q <= ST_ADV_MID;
				end
				ST_ADV_MID: begin
					up_q    <= rd_word;
					state_q <= ST_ADV_DN0;
				end
				ST_ADV_DN0: begin
					mid_q   <= rd_word;
					row0_q  <= rd_word;
					cur_q   <= '0;
					state_q <= ST_ADV_ROW;
				end
				ST_ADV_ROW: begin
					up_q      <= mid_q;
					mid_q     <= dn_word;
					changed_q <= changed_q | row_chg;
					cur_q     <= cur_q + lca_pkg::row_t'(1);
					if (last_row) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, any_changed_q, read_value_q};

`ifndef SYNTHESIS
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("grid row written and read in the same cycle");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV_ROW) |-> (lca_pkg::size_t'(cur_q) < rows_use))
		else $error("advance sweep beyond rows in use");

	a_sweep_marks_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV_ROW && last_row) |=> (valid_q[0] && state_q == ST_DONE))
		else $error("advance finished without writing back the grid");
`endif

endmodule

/* test/tb_top.sv */
// Testbench for lifelike_automaton_generation_step: directed table, then random
// command phases under several rule and size settings, checked by a grid predictor.
// Depends on lca_pkg and the rtl top level only.
`timescale 1ns / 100ps

module tb_top;
	import lca_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASES       = 14;
	localparam int PHASE_ITEMS  = 124;
	localparam int TAIL_CYCLES  = 80;

	typedef struct packed {
		bit read_value;
		bit any_changed;
	} outcome_t;

	typedef struct {
		bit         is_rule;
		logic [8:0] birth_d;
		logic [8:0] surv_d;
		logic [8:0] cols_d;
		logic [8:0] rows_d;
		cmd_e       cmd;
		col_t       col;
		row_t       row;
		bit         val;
		bit         fixed;
		outcome_t   fixed_out;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // command[1:0], col[7:2], row[13:8], cell_value[14]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // read_value[0], any_changed[1]
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;

	lifelike_automaton_generation_step uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// grid predictor state
	bit         life [MAX_ROWS][MAX_COLS];
	mask_t      born_mask = 9'd8;
	mask_t      keep_mask = 9'd12;
	size_t      cols_reg = 7'd64;
	size_t      rows_reg = 7'd64;

	outcome_t   pending_outcomes [$];
	int         mismatches = 0;
	int         send_idle = 17;
	int         recv_idle = 83;
	int         cycle_count = 0;
	plan_row_t  plan [$];

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int unsigned size_in_use(size_t v, int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return 32'(v);
	endfunction

	function automatic bit next_generation();
		int unsigned rows, cols, up, dn, lf, rt, nb;
		bit fresh [MAX_ROWS][MAX_COLS];
		bit changed, nv;
		rows = size_in_use(rows_reg, MAX_ROWS);
		cols = size_in_use(cols_reg, MAX_COLS);
		changed = 1'b0;
		for (int unsigned r = 0; r < rows; r++) begin
			for (int unsigned c = 0; c < cols; c++) begin
				up = (r + rows - 1) % rows;
				dn = (r + 1) % rows;
				lf = (c + cols - 1) % cols;
				rt = (c + 1) % cols;
				nb = 32'(life[up][lf]) + 32'(life[up][c]) + 32'(life[up][rt])
					+ 32'(life[r][lf]) + 32'(life[r][rt]) + 32'(life[dn][lf])
					+ 32'(life[dn][c]) + 32'(life[dn][rt]);
				nv = life[r][c] ? keep_mask[nb] : born_mask[nb];
				if (nv != life[r][c])
					changed = 1'b1;
				fresh[r][c] = nv;
			end
		end
		for (int unsigned r = 0; r < rows; r++)
			for (int unsigned c = 0; c < cols; c++)
				life[r][c] = fresh[r][c];
		return changed;
	endfunction

	function automatic outcome_t run_command(cmd_e cmd, col_t col, row_t row, bit val);
		int unsigned rows, cols, r, c;
		outcome_t res;
		rows = size_in_use(rows_reg, MAX_ROWS);
		cols = size_in_use(cols_reg, MAX_COLS);
		c = (32'(col) >= cols) ? cols - 1 : 32'(col);
		r = (32'(row) >= rows) ? rows - 1 : 32'(row);
		res = '0;
		case (cmd)
			CMD_WRITE: life[r][c] = val;
			CMD_READ: res.read_value = life[r][c];
			CMD_ADVANCE: res.any_changed = next_generation();
			default: begin
				foreach (life[i, j])
					life[i][j] = val;
			end
		endcase
		return res;
	endfunction

	function automatic plan_row_t op(cmd_e cmd, int col, int row, bit val);
		plan_row_t p;
		p = '{default: '0, cmd: cmd};
		p.col = col_t'(col);
		p.row = row_t'(row);
		p.val = val;
		return p;
	endfunction

	function automatic plan_row_t chk(cmd_e cmd, int col, int row, bit val, bit rd, bit chg);
		plan_row_t p;
		p = op(cmd, col, row, val);
		p.fixed = 1'b1;
		p.fixed_out.read_value = rd;
		p.fixed_out.any_changed = chg;
		return p;
	endfunction

	function automatic plan_row_t rule(logic [8:0] b, logic [8:0] s, logic [8:0] c,
			logic [8:0] r);
		plan_row_t p;
		p = '{default: '0, cmd: CMD_READ};
		p.is_rule = 1'b1;
		p.birth_d = b;
		p.surv_d = s;
		p.cols_d = c;
		p.rows_d = r;
		return p;
	endfunction

	function automatic logic [8:0] pick_mask(logic [8:0] usual);
		case ($urandom_range(4))
			0: return usual;
			1: return 9'h000;
			2: return 9'h1FF;
			default: return 9'($urandom_range(511));
		endcase
	endfunction

	function automatic logic [8:0] pick_size();
		int unsigned k;
		logic [6:0] v;
		k = $urandom_range(9);
		if (k < 6)
			v = 7'($urandom_range(12, 1));
		else if (k == 6)
			v = 7'd0;
		else if (k == 7)
			v = 7'd64;
		else if (k == 8)
			v = 7'($urandom_range(127, 65));
		else
			v = 7'($urandom_range(63, 13));
		return {2'($urandom_range(3)), v};
	endfunction

	// hold valid low and wait until every result is back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_rule(logic [8:0] b, logic [8:0] s, logic [8:0] c, logic [8:0] r);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BIRTH;
		cfg_data <= b;
		@(posedge clk);
		born_mask = b;
		cfg_index <= CFG_SURVIVAL;
		cfg_data <= s;
		@(posedge clk);
		keep_mask = s;
		cfg_index <= CFG_COLS;
		cfg_data <= c;
		@(posedge clk);
		cols_reg = c[6:0];
		cfg_index <= CFG_ROWS;
		cfg_data <= r;
		@(posedge clk);
		rows_reg = r[6:0];
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(cmd_e cmd, col_t col, row_t row, bit val, bit fixed,
			outcome_t fixed_out);
		outcome_t res;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {1'b0, val, row, col, cmd};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		res = run_command(cmd, col, row, val);
		pending_outcomes.push_back(fixed ? fixed_out : res);
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t unexpected item: expected none, actual %h", $time, m_tdata);
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				if (m_tdata[0] !== want.read_value) begin
					$display("%0t read_value: expected %0d, actual %0d", $time,
						want.read_value, m_tdata[0]);
					mismatches++;
				end
				if (m_tdata[1] !== want.any_changed) begin
					$display("%0t any_changed: expected %0d, actual %0d", $time,
						want.any_changed, m_tdata[1]);
					mismatches++;
				end
				if (m_tdata[7:2] !== 6'd0) begin
					$display("%0t padding: expected 0, actual %h", $time, m_tdata[7:2]);
					mismatches++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		int unsigned cols, rows, pick, fill_bias;
		cmd_e cmd;
		col_t col;
		row_t row;

		plan.push_back(chk(CMD_READ, 0, 0, 0, 0, 0));
		plan.push_back(chk(CMD_READ, 63, 63, 0, 0, 0));
		plan.push_back(chk(CMD_ADVANCE, 0, 0, 0, 0, 0));
		plan.push_back(chk(CMD_WRITE, 63, 63, 1, 0, 0));
		plan.push_back(chk(CMD_READ, 63, 63, 0, 1, 0));
		plan.push_back(chk(CMD_WRITE, 63, 63, 0, 0, 0));
		plan.push_back(op(CMD_WRITE, 63, 0, 1));
		plan.push_back(op(CMD_WRITE, 0, 0, 1));
		plan.push_back(op(CMD_WRITE, 1, 0, 1));
		plan.push_back(op(CMD_ADVANCE, 0, 0, 0));
		plan.push_back(op(CMD_READ, 0, 63, 0));
		plan.push_back(op(CMD_READ, 0, 1, 0));
		plan.push_back(op(CMD_ADVANCE, 0, 0, 0));
		plan.push_back(op(CMD_READ, 63, 0, 0));
		plan.push_back(chk(CMD_CLEAR, 5, 9, 1, 0, 0));
		plan.push_back(chk(CMD_READ, 17, 42, 0, 1, 0));
		plan.push_back(chk(CMD_ADVANCE, 0, 0, 0, 0, 1));
		plan.push_back(chk(CMD_READ, 0, 0, 0, 0, 0));
		plan.push_back(chk(CMD_ADVANCE, 0, 0, 0, 0, 0));
		plan.push_back(rule(9'd8, 9'd12, 9'd0, 9'd2));
		plan.push_back(op(CMD_WRITE, 40, 50, 1));
		plan.push_back(op(CMD_READ, 0, 1, 0));
		plan.push_back(op(CMD_ADVANCE, 0, 0, 0));
		plan.push_back(op(CMD_READ, 63, 63, 0));
		plan.push_back(rule(9'h1FF, 9'h1FF, 9'h1FF, 9'h17F));
		plan.push_back(op(CMD_ADVANCE, 0, 0, 0));
		plan.push_back(op(CMD_READ, 33, 33, 0));
		plan.push_back(rule(9'h000, 9'h000, 9'd64, 9'd64));
		plan.push_back(op(CMD_ADVANCE, 0, 0, 0));
		plan.push_back(op(CMD_READ, 62, 1, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_rule) begin
				settle();
				write_rule(plan[i].birth_d, plan[i].surv_d, plan[i].cols_d, plan[i].rows_d);
			end else begin
				send_item(plan[i].cmd, plan[i].col, plan[i].row, plan[i].val,
					plan[i].fixed, plan[i].fixed_out);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 5) begin
				send_idle = 17;
				recv_idle = 83;
			end else if (ph < 10) begin
				send_idle = 83;
				recv_idle = 17;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			settle();
			write_rule(pick_mask(9'd8), pick_mask(9'd12), pick_size(), pick_size());
			cols = size_in_use(cols_reg, MAX_COLS);
			rows = size_in_use(rows_reg, MAX_ROWS);
			fill_bias = $urandom_range(80, 20);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 38)
					cmd = CMD_WRITE;
				else if (pick < 72)
					cmd = CMD_READ;
				else if (pick < 93)
					cmd = CMD_ADVANCE;
				else
					cmd = CMD_CLEAR;
				if ($urandom_range(1)) begin
					col = col_t'($urandom_range(cols - 1, 0));
					row = row_t'($urandom_range(rows - 1, 0));
				end else begin
					col = col_t'($urandom_range(63, 0));
					row = row_t'($urandom_range(63, 0));
				end
				send_item(cmd, col, row, ($urandom_range(99) < fill_bias), 1'b0, '0);
				if ($urandom_range(59) == 0)
					settle();
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* lifelike_automaton_generation_step.f */
rtl/lca_pkg.sv
rtl/lca_ram.sv
rtl/lca_row_unit.sv
rtl/lifelike_automaton_generation_step.sv
test/tb_top.sv
